[hw/rtl/i2c_bs_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
// Used by every module under hw/rtl; no dependencies.
package i2c_bs_pkg;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_NACK  = 3'd5,
        CMD_WAIT  = 3'd6,
        CMD_IDLE  = 3'd7
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       sda_sample;
    } t_in_word;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       no_ack;
    } t_out_word;

    // classified item handed from the front to the back
    typedef struct packed {
        logic       tick;
        logic       start_ok;
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       sample;
    } t_op;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] TIMEOUT_RESET = 8'd250;

    // phase numbers
    localparam logic [4:0] PH_BITS_END = 5'd24; // write: last bit phase + 1; read: last sample
    localparam logic [4:0] PH_RD_LAST  = 5'd25;
    localparam logic [4:0] PH_POLL     = 5'd2;
    localparam logic [4:0] PH_TO_SDA0  = 5'd3;
    localparam logic [4:0] PH_TO_SCL1  = 5'd4;
    localparam logic [4:0] PH_TO_SDA1  = 5'd5;
    localparam logic [4:0] PH_WAIT_END = 5'd6;

endpackage

[hw/rtl/i2c_bs_front.sv]
// Front end: takes input words and classifies them into queue entries.
// Depends on i2c_bs_pkg.
module i2c_bs_front
    import i2c_bs_pkg::*;
(
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_op      o_op
);

    t_cmd w_cmd;

    assign w_cmd      = t_cmd'(i_in_word.command);
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_op.tick     = i_in_word.kind;
        // a command code of idle never starts anything
        o_op.start_ok = !i_in_word.kind && (w_cmd != CMD_IDLE);
        o_op.cmd      = w_cmd;
        o_op.tx_byte  = (w_cmd == CMD_WRITE) ? i_in_word.tx_byte : 8'd0;
        o_op.sample   = i_in_word.sda_sample;
    end

endmodule

[hw/rtl/i2c_bs_queue.sv]
// Short register queue between front and back end.
// Depends on i2c_bs_pkg.
module i2c_bs_queue
    import i2c_bs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_head
);

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_CW-1:0] r_cnt, n_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue count over depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointer gap");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

endmodule

[hw/rtl/i2c_bs_back.sv]
// Back end: runs command phases on the bus state, holds the timeout register
// and the result register. Depends on i2c_bs_pkg.
module i2c_bs_back
    import i2c_bs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_q_valid,
    input  t_op       i_q_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd       r_cmd, n_cmd;
    logic [4:0] r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_wait, n_wait;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_nack, n_nack;
    logic [7:0] r_timeout;
    logic       n_done;
    logic [4:0] w_phase_nx;
    logic [1:0] w_sub_nx;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out, n_out;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_sub_nx    = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;

    // next state of the sequencer
    always_comb begin
        n_cmd      = r_cmd;
        n_phase    = r_phase;
        n_sub      = r_sub;
        n_shift    = r_shift;
        n_wait     = r_wait;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_rx       = r_rx;
        n_nack     = r_nack;
        n_done     = 1'b0;
        w_phase_nx = r_phase + 5'd1;
        if (o_pop) begin
            if (!i_q_head.tick) begin
                if (i_q_head.start_ok && (r_cmd == CMD_IDLE)) begin
                    n_cmd   = i_q_head.cmd;
                    n_phase = '0;
                    n_sub   = '0;
                    n_wait  = '0;
                    n_shift = i_q_head.tx_byte;
                    if (i_q_head.cmd == CMD_WAIT) begin
                        n_nack = 1'b0;
                    end
                end
            end else if (r_cmd != CMD_IDLE) begin
                unique case (r_cmd)
                    CMD_START: begin
                        priority if (r_phase == 5'd0) n_sda = 1'b1;
                        else if (r_phase == 5'd1) n_scl = 1'b1;
                        else if (r_phase == 5'd2) n_sda = 1'b0;
                        else begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        priority if (r_phase == 5'd0) n_sda = 1'b0;
                        else if (r_phase == 5'd1) n_scl = 1'b1;
                        else begin
                            n_sda  = 1'b1;
                            n_done = 1'b1;
                        end
                    end
                    CMD_ACK, CMD_NACK: begin
                        priority if (r_phase == 5'd0) n_sda = (r_cmd == CMD_NACK);
                        else if (r_phase == 5'd1) n_scl = 1'b1;
                        else begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                    CMD_WRITE: begin
                        if (r_phase < PH_BITS_END) begin
                            n_sub = w_sub_nx;
                            unique case (r_sub)
                                2'd0: n_scl = 1'b0;
                                2'd1: begin
                                    n_sda   = r_shift[7];
                                    n_shift = {r_shift[6:0], 1'b0};
                                end
                                default: n_scl = 1'b1;
                            endcase
                        end else begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        priority if (r_phase == 5'd0) begin
                            n_sda = 1'b1;
                        end else if (r_phase <= PH_BITS_END) begin
                            n_sub = w_sub_nx;
                            unique case (r_sub)
                                2'd0: n_scl = 1'b0;
                                2'd1: n_scl = 1'b1;
                                default: n_shift = {r_shift[6:0], i_q_head.sample};
                            endcase
                        end else begin
                            n_scl  = 1'b0;
                            n_rx   = r_shift;
                            n_done = 1'b1;
                        end
                    end
                    CMD_WAIT: begin
                        priority if (r_phase == 5'd0) begin
                            n_sda = 1'b1;
                        end else if (r_phase == 5'd1) begin
                            n_scl = 1'b1;
                        end else if (r_phase == PH_POLL) begin
                            priority if (!i_q_head.sample) begin
                                w_phase_nx = PH_WAIT_END;
                            end else if (r_wait >= r_timeout) begin
                                // timed out: fall into the stop phases
                                n_nack     = 1'b1;
                                w_phase_nx = PH_TO_SDA0;
                            end else begin
                                n_wait     = r_wait + 8'd1;
                                w_phase_nx = PH_POLL;
                            end
                        end else if (r_phase == PH_TO_SDA0) begin
                            n_sda = 1'b0;
                        end else if (r_phase == PH_TO_SCL1) begin
                            n_scl = 1'b1;
                        end else if (r_phase == PH_TO_SDA1) begin
                            n_sda = 1'b1;
                        end else begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                    default: n_done = 1'b1;
                endcase
                n_phase = w_phase_nx;
                if (n_done) begin
                    n_cmd   = CMD_IDLE;
                    n_phase = '0;
                end
            end
        end
    end

    // result word and output register control
    always_comb begin
        n_out.scl_drive = n_scl;
        n_out.sda_drive = n_sda;
        n_out.busy_res  = (n_cmd != CMD_IDLE);
        n_out.done_res  = n_done;
        n_out.rx_byte   = n_rx;
        n_out.no_ack    = n_nack;
        n_out_valid     = o_pop || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_IDLE;
            r_phase     <= '0;
            r_sub       <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= '0;
            r_nack      <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd       <= n_cmd;
            r_phase     <= n_phase;
            r_sub       <= n_sub;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_rx        <= n_rx;
            r_nack      <= n_nack;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_IDLE) |-> (r_phase == '0))
        else $error("idle with nonzero phase");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_RD_LAST)
        else $error("phase out of range");

    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub != 2'd3)
        else $error("bit sub-phase out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done word still busy");

endmodule

[hw/rtl/i2c_bs_top_unused_guard.sv]
// Configuration write path from the top level ports to the back end.
// Depends on i2c_bs_pkg.
module i2c_bs_cfg
    import i2c_bs_pkg::*;
(
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_we,
    output logic [7:0] o_wdata
);

    assign o_we    = i_cfg_we;
    assign o_wdata = i_cfg_wdata;

endmodule

[hw/rtl/i2c_master_bit_sequencer.sv]
// Top level of the I2C master bit sequencer: front classifier, queue, back end.
// Depends on i2c_bs_pkg, i2c_bs_front, i2c_bs_queue, i2c_bs_back, i2c_bs_cfg.
//
// Usage: input words (a command or one bit-period tick with the sampled SDA
// level) arrive on i_in_valid/i_in_word and are taken at an edge where
// o_in_stall is low. Every input word yields exactly one result word on
// o_out_valid/o_out_word, taken at an edge where i_out_stall is low; results
// come out in input order and show SCL/SDA drive levels, busy, done, the last
// byte read and the ack-timeout flag.
// An accepted word sits in the two-entry queue until the back end pops it,
// and its result is registered as it is popped. Throughput is one word per
// cycle when the receiver does not stall; the back end handles each word combinationally.
// When the receiver stalls, the result register holds and the queue fills;
// o_in_stall rises once both queue entries are in use.
// i_cfg_we/i_cfg_wdata write the ack timeout (reset 250); write it only while
// no word is in flight. Synchronous reset (i_rst_n low) leaves both lines
// released, no command active, queue and result register empty.
module i2c_master_bit_sequencer
    import i2c_bs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    logic       w_push, w_full, w_q_valid, w_pop;
    t_op        w_push_op, w_head;
    logic       w_cfg_we;
    logic [7:0] w_cfg_wdata;

    i2c_bs_cfg u_cfg (
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_we        (w_cfg_we),
        .o_wdata     (w_cfg_wdata)
    );

    i2c_bs_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_full     (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_op       (w_push_op)
    );

    i2c_bs_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .o_full    (w_full),
        .i_pop     (w_pop),
        .o_valid   (w_q_valid),
        .o_head    (w_head)
    );

    i2c_bs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_wdata (w_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
